@@ design/stl_pkg.sv @@
// SQL token lexer package: result and mode types, kind and error codes,
// character class functions. No dependencies.
package stl_pkg;

    localparam logic [2:0] KIND_WORD   = 3'd0;
    localparam logic [2:0] KIND_NUMBER = 3'd1;
    localparam logic [2:0] KIND_STRING = 3'd2;
    localparam logic [2:0] KIND_SYMBOL = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_BYTE = 2'd1;
    localparam logic [1:0] ERR_OPEN_STR = 2'd2;
    localparam logic [1:0] ERR_EMPTY    = 2'd3;

    localparam logic [1:0] MARK_START = 2'd0;
    localparam logic [1:0] MARK_EF    = 2'd1;
    localparam logic [1:0] MARK_EFBB  = 2'd2;
    localparam logic [1:0] MARK_DONE  = 2'd3;

    localparam logic [7:0] CH_MARK0 = 8'hEF;
    localparam logic [7:0] CH_MARK1 = 8'hBB;
    localparam logic [7:0] CH_MARK2 = 8'hBF;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef enum logic [6:0] {
        MODE_IDLE   = 7'b0000001,
        MODE_WORD   = 7'b0000010,
        MODE_NUMBER = 7'b0000100,
        MODE_MINUS  = 7'b0001000,
        MODE_STRING = 7'b0010000,
        MODE_QUOTE  = 7'b0100000,
        MODE_ERROR  = 7'b1000000
    } t_mode;

    typedef struct packed {
        logic [2:0] kind;
        logic       char_valid;
        logic [7:0] ch;
        logic       done;
        logic [1:0] err;
        logic       last;
    } t_result;

    // outcome of a byte seen between tokens
    typedef struct packed {
        t_mode   mode;
        logic    seen;
        logic    has_res;
        t_result res;
    } t_between;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return is_alpha(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return is_word_start(c) || is_digit(c);
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        return (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_COMMA) ||
               (c == CH_STAR) || (c == CH_EQ) || (c == CH_SEMI);
    endfunction

    function automatic t_result mk_res(input logic [2:0] kind, input logic cv,
                                       input logic [7:0] ch, input logic done,
                                       input logic [1:0] err);
        t_result r;
        r.kind       = kind;
        r.char_valid = cv;
        r.ch         = ch;
        r.done       = done;
        r.err        = err;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic t_between between_tokens(input logic [7:0] c);
        t_between b;
        b.mode    = MODE_IDLE;
        b.seen    = 1'b0;
        b.has_res = 1'b0;
        b.res     = mk_res(KIND_END, 1'b0, 8'h00, 1'b0, ERR_NONE);
        if (is_space(c)) begin
            b.mode = MODE_IDLE;
        end else if (is_word_start(c)) begin
            b.mode    = MODE_WORD;
            b.seen    = 1'b1;
            b.has_res = 1'b1;
            b.res     = mk_res(KIND_WORD, 1'b1, c, 1'b0, ERR_NONE);
        end else if (is_digit(c)) begin
            b.mode    = MODE_NUMBER;
            b.seen    = 1'b1;
            b.has_res = 1'b1;
            b.res     = mk_res(KIND_NUMBER, 1'b1, c, 1'b0, ERR_NONE);
        end else if (c == CH_MINUS) begin
            b.mode = MODE_MINUS;
        end else if (c == CH_QUOTE) begin
            b.mode = MODE_STRING;
            b.seen = 1'b1;
        end else if (is_symbol(c)) begin
            b.mode    = MODE_IDLE;
            b.seen    = 1'b1;
            b.has_res = 1'b1;
            b.res     = mk_res(KIND_SYMBOL, 1'b1, c, 1'b1, ERR_NONE);
        end else begin
            b.mode    = MODE_ERROR;
            b.has_res = 1'b1;
            b.res     = mk_res(KIND_END, 1'b0, 8'h00, 1'b0, ERR_BAD_BYTE);
        end
        return b;
    endfunction

endpackage

@@ design/stl_in_if.sv @@
// Byte input channel of the SQL token lexer: valid/ready plus byte payload.
// No dependencies.
interface stl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       statement_end;

    modport source (output valid, output text_byte, output statement_end, input ready);
    modport sink   (input valid, input text_byte, input statement_end, output ready);
endinterface

@@ design/stl_out_if.sv @@
// Token result channel of the SQL token lexer: valid/ready plus result fields.
// No dependencies.
interface stl_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] token_kind;
    logic       char_valid;
    logic [7:0] token_char;
    logic       token_done;
    logic [1:0] error_code;
    logic       last_result;

    modport source (output valid, output token_kind, output char_valid, output token_char,
                    output token_done, output error_code, output last_result,
                    input ready);
    modport sink   (input valid, input token_kind, input char_valid, input token_char,
                    input token_done, input error_code, input last_result,
                    output ready);
endinterface

@@ design/sql_token_lexer_core.sv @@
// SQL token lexer core: byte register, lexer state machine, two-entry result queue.
// Depends on stl_pkg, stl_in_if, stl_out_if.
//
// Usage: statement bytes enter on i_text, one per transfer; a transfer with
// statement_end set closes the statement and carries no byte. Token characters
// leave on o_token, one result per transfer, tagged by kind; last_result marks
// the final result caused by one input transfer (an input may cause 0, 1 or 2).
// An accepted byte is registered in the byte register, then processed into the
// result queue register, from which its first result is offered.
// Throughput: one input per cycle while the receiver is ready and each input
// causes at most one result; an input causing two results holds the queue
// for two output transfers. The lexer state advances only when the result queue
// will be empty after the current cycle, so a stalled receiver backs up into the
// byte register and then drops i_text.ready; nothing is lost. Reset (synchronous,
// active low) empties both registers and returns the lexer to the start of a
// statement; every end marker does the same to the lexer state.
module sql_token_lexer_core
    import stl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    stl_in_if.sink     i_text,
    stl_out_if.source  o_token
);

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_end;

    t_mode      r_mode, n_mode;
    logic [1:0] r_mark, n_mark;
    logic       r_seen, n_seen;

    t_result    r_res0, r_res1, n_res0, n_res1;
    logic [1:0] r_cnt, n_cnt;

    logic in_fire, out_fire, room, proc_fire;

    assign out_fire  = o_token.valid && o_token.ready;
    assign room      = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_token.ready);
    assign proc_fire = r_in_valid && room;
    assign i_text.ready = !r_in_valid || proc_fire;
    assign in_fire   = i_text.valid && i_text.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
        if (in_fire) begin
            r_byte <= i_text.text_byte;
            r_end  <= i_text.statement_end;
        end
    end

    // lexer step
    always_comb begin
        t_result  res [2];
        t_between b;
        logic     k;
        logic     go;
        logic     failed;
        logic [1:0] cnt;

        n_mode = r_mode;
        n_mark = r_mark;
        n_seen = r_seen;
        res[0] = mk_res(KIND_END, 1'b0, 8'h00, 1'b0, ERR_NONE);
        res[1] = res[0];
        k      = 1'b0;
        go     = 1'b1;
        failed = 1'b0;
        cnt    = 2'd0;
        b      = between_tokens(r_byte);

        if (r_end) begin
            if (r_mode != MODE_ERROR) begin
                if ((r_mark == MARK_EF) || (r_mark == MARK_EFBB)) begin
                    res[0] = mk_res(KIND_END, 1'b0, 8'h00, 1'b0, ERR_BAD_BYTE);
                    failed = 1'b1;
                    cnt    = 2'd1;
                end else begin
                    unique case (r_mode)
                        MODE_WORD: begin
                            res[0] = mk_res(KIND_WORD, 1'b0, 8'h00, 1'b1, ERR_NONE);
                            k      = 1'b1;
                        end
                        MODE_NUMBER: begin
                            res[0] = mk_res(KIND_NUMBER, 1'b0, 8'h00, 1'b1, ERR_NONE);
                            k      = 1'b1;
                        end
                        MODE_QUOTE: begin
                            res[0] = mk_res(KIND_STRING, 1'b0, 8'h00, 1'b1, ERR_NONE);
                            k      = 1'b1;
                        end
                        MODE_STRING: begin
                            res[0] = mk_res(KIND_END, 1'b0, 8'h00, 1'b0, ERR_OPEN_STR);
                            failed = 1'b1;
                            cnt    = 2'd1;
                        end
                        MODE_MINUS: begin
                            res[0] = mk_res(KIND_END, 1'b0, 8'h00, 1'b0, ERR_BAD_BYTE);
                            failed = 1'b1;
                            cnt    = 2'd1;
                        end
                        default: ;
                    endcase
                    if (!failed) begin
                        if (!r_seen) begin
                            res[k] = mk_res(KIND_END, 1'b0, 8'h00, 1'b0, ERR_EMPTY);
                        end else begin
                            res[k] = mk_res(KIND_END, 1'b0, 8'h00, 1'b1, ERR_NONE);
                        end
                        cnt = k ? 2'd2 : 2'd1;
                    end
                end
            end
            n_mode = MODE_IDLE;
            n_mark = MARK_START;
            n_seen = 1'b0;
        end else if (r_mode != MODE_ERROR) begin
            // leading byte order mark
            unique case (r_mark)
                MARK_START: begin
                    if (r_byte == CH_MARK0) begin
                        n_mark = MARK_EF;
                        go     = 1'b0;
                    end else begin
                        n_mark = MARK_DONE;
                    end
                end
                MARK_EF: begin
                    go = 1'b0;
                    if (r_byte == CH_MARK1) begin
                        n_mark = MARK_EFBB;
                    end else begin
                        n_mark = MARK_DONE;
                        failed = 1'b1;
                    end
                end
                MARK_EFBB: begin
                    go     = 1'b0;
                    n_mark = MARK_DONE;
                    failed = (r_byte != CH_MARK2);
                end
                default: ;
            endcase

            if (go) begin
                unique case (r_mode)
                    MODE_WORD: begin
                        if (is_word_char(r_byte)) begin
                            res[0] = mk_res(KIND_WORD, 1'b1, r_byte, 1'b0, ERR_NONE);
                            cnt    = 2'd1;
                        end else begin
                            res[0] = mk_res(KIND_WORD, 1'b0, 8'h00, 1'b1, ERR_NONE);
                            cnt    = 2'd1;
                            k      = 1'b1;
                        end
                    end
                    MODE_NUMBER: begin
                        if (is_digit(r_byte)) begin
                            res[0] = mk_res(KIND_NUMBER, 1'b1, r_byte, 1'b0, ERR_NONE);
                            cnt    = 2'd1;
                        end else begin
                            res[0] = mk_res(KIND_NUMBER, 1'b0, 8'h00, 1'b1, ERR_NONE);
                            cnt    = 2'd1;
                            k      = 1'b1;
                        end
                    end
                    MODE_MINUS: begin
                        if (!is_digit(r_byte)) begin
                            failed = 1'b1;
                        end else begin
                            n_seen = 1'b1;
                            n_mode = MODE_NUMBER;
                            res[0] = mk_res(KIND_NUMBER, 1'b1, CH_MINUS, 1'b0, ERR_NONE);
                            res[1] = mk_res(KIND_NUMBER, 1'b1, r_byte, 1'b0, ERR_NONE);
                            cnt    = 2'd2;
                        end
                    end
                    MODE_STRING: begin
                        if (r_byte == CH_QUOTE) begin
                            n_mode = MODE_QUOTE;
                        end else begin
                            res[0] = mk_res(KIND_STRING, 1'b1, r_byte, 1'b0, ERR_NONE);
                            cnt    = 2'd1;
                        end
                    end
                    MODE_QUOTE: begin
                        if (r_byte == CH_QUOTE) begin
                            n_mode = MODE_STRING;
                            res[0] = mk_res(KIND_STRING, 1'b1, r_byte, 1'b0, ERR_NONE);
                            cnt    = 2'd1;
                        end else begin
                            res[0] = mk_res(KIND_STRING, 1'b0, 8'h00, 1'b1, ERR_NONE);
                            cnt    = 2'd1;
                            k      = 1'b1;
                        end
                    end
                    MODE_IDLE: begin
                        k = 1'b0;
                    end
                    default: ;
                endcase

                // terminating byte handled as between tokens
                if ((r_mode == MODE_IDLE) || k) begin
                    n_mode = b.mode;
                    if (b.seen) begin
                        n_seen = 1'b1;
                    end
                    if (b.has_res) begin
                        res[k] = b.res;
                        cnt    = k ? 2'd2 : 2'd1;
                    end
                end
            end

            if (failed) begin
                n_mode = MODE_ERROR;
                res[0] = mk_res(KIND_END, 1'b0, 8'h00, 1'b0, ERR_BAD_BYTE);
                cnt    = 2'd1;
            end
        end

        if (cnt == 2'd2) begin
            res[1].last = 1'b1;
        end else if (cnt == 2'd1) begin
            res[0].last = 1'b1;
        end

        // result queue
        n_res0 = r_res0;
        n_res1 = r_res1;
        n_cnt  = r_cnt;
        if (proc_fire) begin
            n_res0 = res[0];
            n_res1 = res[1];
            n_cnt  = cnt;
        end else if (out_fire) begin
            n_res0 = r_res1;
            n_cnt  = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_mark <= MARK_START;
            r_seen <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (proc_fire) begin
                r_mode <= n_mode;
                r_mark <= n_mark;
                r_seen <= n_seen;
            end
            r_cnt <= n_cnt;
        end
        r_res0 <= n_res0;
        r_res1 <= n_res1;
    end

    assign o_token.valid       = (r_cnt != 2'd0);
    assign o_token.token_kind  = r_res0.kind;
    assign o_token.char_valid  = r_res0.char_valid;
    assign o_token.token_char  = r_res0.ch;
    assign o_token.token_done  = r_res0.done;
    assign o_token.error_code  = r_res0.err;
    assign o_token.last_result = r_res0.last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && r_end |=> (r_mode == MODE_IDLE) && (r_mark == MARK_START) && !r_seen)
        else $error("end marker did not return lexer to start");

    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !r_res0.last && r_res1.last)
        else $error("queued result pair has wrong last flags");

    a_error_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && !r_end && (r_mode == MODE_ERROR) |=> r_cnt == 2'd0)
        else $error("byte after error produced a result");

endmodule

@@ bench/stl_lexer_checker.sv @@
`timescale 1ns / 100ps
// Token stream checker for sql_token_lexer_core: tracks the lexer state per byte transfer,
// queues the token results each transfer should cause and compares them in order.
// Depends on stl_pkg, stl_in_if, stl_out_if.
module stl_lexer_checker
    import stl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    stl_in_if    i_text,
    stl_out_if   i_token,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    t_mode      lex_mode;
    logic [1:0] bom_pos;
    logic       tok_seen;
    t_result    want_q[$];
    int         fail_total    = 0;
    int         checked_total = 0;

    assign o_fail_count = fail_total;
    assign o_checked    = checked_total;

    task automatic report_mismatch(input string what);
        fail_total++;
        if (fail_total <= 40) begin
            $display("ERROR %0t: result %0d: %s", $time, checked_total, what);
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    function automatic logic cls_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic cls_head(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER};
    endfunction

    function automatic logic cls_punct(input logic [7:0] c);
        return c inside {CH_LPAR, CH_RPAR, CH_COMMA, CH_STAR, CH_EQ, CH_SEMI};
    endfunction

    task automatic want_result(input logic [2:0] kind, input logic cv, input logic [7:0] ch,
                               input logic done, input logic [1:0] err);
        t_result r;
        r.kind       = kind;
        r.char_valid = cv;
        r.ch         = ch;
        r.done       = done;
        r.err        = err;
        r.last       = 1'b0;
        want_q = {want_q, r};
    endtask

    task automatic lex_fail(input logic [1:0] err);
        lex_mode = MODE_ERROR;
        want_result(KIND_END, 1'b0, 8'h00, 1'b0, err);
    endtask

    task automatic lex_reset();
        lex_mode = MODE_IDLE;
        bom_pos  = MARK_START;
        tok_seen = 1'b0;
    endtask

    // byte seen while no word, number or string is open
    task automatic lex_lead(input logic [7:0] c);
        if (c == 8'h20 || c inside {[8'h09:8'h0D]}) begin
            lex_mode = MODE_IDLE;
        end else if (cls_head(c)) begin
            tok_seen = 1'b1;
            lex_mode = MODE_WORD;
            want_result(KIND_WORD, 1'b1, c, 1'b0, ERR_NONE);
        end else if (cls_digit(c)) begin
            tok_seen = 1'b1;
            lex_mode = MODE_NUMBER;
            want_result(KIND_NUMBER, 1'b1, c, 1'b0, ERR_NONE);
        end else if (c == CH_MINUS) begin
            lex_mode = MODE_MINUS;
        end else if (c == CH_QUOTE) begin
            tok_seen = 1'b1;
            lex_mode = MODE_STRING;
        end else if (cls_punct(c)) begin
            tok_seen = 1'b1;
            lex_mode = MODE_IDLE;
            want_result(KIND_SYMBOL, 1'b1, c, 1'b1, ERR_NONE);
        end else begin
            lex_fail(ERR_BAD_BYTE);
        end
    endtask

    task automatic lex_close_stmt();
        if (lex_mode == MODE_ERROR) return;
        if (bom_pos == MARK_EF || bom_pos == MARK_EFBB) begin
            lex_fail(ERR_BAD_BYTE);
            return;
        end
        case (lex_mode)
            MODE_WORD:   want_result(KIND_WORD, 1'b0, 8'h00, 1'b1, ERR_NONE);
            MODE_NUMBER: want_result(KIND_NUMBER, 1'b0, 8'h00, 1'b1, ERR_NONE);
            MODE_QUOTE:  want_result(KIND_STRING, 1'b0, 8'h00, 1'b1, ERR_NONE);
            MODE_STRING: begin
                lex_fail(ERR_OPEN_STR);
                return;
            end
            MODE_MINUS: begin
                lex_fail(ERR_BAD_BYTE);
                return;
            end
            default: ;
        endcase
        if (!tok_seen) begin
            lex_fail(ERR_EMPTY);
        end else begin
            want_result(KIND_END, 1'b0, 8'h00, 1'b1, ERR_NONE);
        end
    endtask

    task automatic lex_take_byte(input logic [7:0] c);
        if (lex_mode == MODE_ERROR) return;
        if (bom_pos == MARK_START) begin
            if (c == CH_MARK0) begin
                bom_pos = MARK_EF;
                return;
            end
            bom_pos = MARK_DONE;
        end else if (bom_pos == MARK_EF) begin
            if (c == CH_MARK1) begin
                bom_pos = MARK_EFBB;
                return;
            end
            bom_pos = MARK_DONE;
            lex_fail(ERR_BAD_BYTE);
            return;
        end else if (bom_pos == MARK_EFBB) begin
            bom_pos = MARK_DONE;
            if (c != CH_MARK2) lex_fail(ERR_BAD_BYTE);
            return;
        end
        case (lex_mode)
            MODE_WORD: begin
                if (cls_head(c) || cls_digit(c)) begin
                    want_result(KIND_WORD, 1'b1, c, 1'b0, ERR_NONE);
                end else begin
                    want_result(KIND_WORD, 1'b0, 8'h00, 1'b1, ERR_NONE);
                    lex_lead(c);
                end
            end
            MODE_NUMBER: begin
                if (cls_digit(c)) begin
                    want_result(KIND_NUMBER, 1'b1, c, 1'b0, ERR_NONE);
                end else begin
                    want_result(KIND_NUMBER, 1'b0, 8'h00, 1'b1, ERR_NONE);
                    lex_lead(c);
                end
            end
            MODE_MINUS: begin
                if (!cls_digit(c)) begin
                    lex_fail(ERR_BAD_BYTE);
                end else begin
                    tok_seen = 1'b1;
                    lex_mode = MODE_NUMBER;
                    want_result(KIND_NUMBER, 1'b1, CH_MINUS, 1'b0, ERR_NONE);
                    want_result(KIND_NUMBER, 1'b1, c, 1'b0, ERR_NONE);
                end
            end
            MODE_STRING: begin
                if (c == CH_QUOTE) begin
                    lex_mode = MODE_QUOTE;
                end else begin
                    want_result(KIND_STRING, 1'b1, c, 1'b0, ERR_NONE);
                end
            end
            MODE_QUOTE: begin
                if (c == CH_QUOTE) begin
                    lex_mode = MODE_STRING;
                    want_result(KIND_STRING, 1'b1, c, 1'b0, ERR_NONE);
                end else begin
                    want_result(KIND_STRING, 1'b0, 8'h00, 1'b1, ERR_NONE);
                    lex_lead(c);
                end
            end
            default: lex_lead(c);
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        int      before_n;
        if (!i_rst_n) begin
            lex_reset();
            want_q.delete();
        end else begin
            if (i_text.valid && i_text.ready) begin
                before_n = want_q.size();
                if (i_text.statement_end) begin
                    lex_close_stmt();
                    lex_reset();
                end else begin
                    lex_take_byte(i_text.text_byte);
                end
                if (want_q.size() > before_n) begin
                    exp_r      = want_q.pop_back();
                    exp_r.last = 1'b1;
                    want_q     = {want_q, exp_r};
                end
            end
            if (i_token.valid && i_token.ready) begin
                checked_total++;
                if (want_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d char %02h",
                                              i_token.token_kind, i_token.token_char));
                end else begin
                    exp_r = want_q.pop_front();
                    check_field("token_kind", i_token.token_kind, exp_r.kind);
                    check_field("char_valid", i_token.char_valid, exp_r.char_valid);
                    check_field("token_char", i_token.token_char, exp_r.ch);
                    check_field("token_done", i_token.token_done, exp_r.done);
                    check_field("error_code", i_token.error_code, exp_r.err);
                    check_field("last_result", i_token.last_result, exp_r.last);
                end
            end
        end
        o_pending <= want_q.size();
    end

endmodule

@@ bench/tb_sql_token_lexer_core.sv @@
`timescale 1ns / 100ps
// Top-level bench for sql_token_lexer_core: drives directed and random SQL statements
// with random gaps and stalls, and gives the verdict from stl_lexer_checker.
// Depends on stl_pkg, stl_in_if, stl_out_if, stl_lexer_checker.
module tb_sql_token_lexer_core
    import stl_pkg::*;
();

    localparam int         CLK_HALF     = 10;
    localparam int         RANDOM_ITEMS = 600;
    localparam int         LIMIT_CYCLES = 200000;
    localparam logic [8:0] END_MARK     = 9'h100;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   calm    = 1'b0;
    int   cycles  = 0;
    int   sent    = 0;
    int   stmts   = 0;
    int   fail_total;
    int   results_due;
    int   checked_total;

    logic [7:0] symbols [6] = '{CH_LPAR, CH_RPAR, CH_COMMA, CH_STAR, CH_EQ, CH_SEMI};

    stl_in_if  text_if ();
    stl_out_if tok_if ();

    sql_token_lexer_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_if),
        .o_token (tok_if)
    );

    stl_lexer_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text       (text_if),
        .i_token      (tok_if),
        .o_fail_count (fail_total),
        .o_pending    (results_due),
        .o_checked    (checked_total)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        tok_if.ready <= calm || ($urandom_range(0, 99) >= 37);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, results_due);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic fin);
        while (!calm && $urandom_range(0, 99) < 37) begin
            text_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        text_if.valid         <= 1'b1;
        text_if.text_byte     <= b;
        text_if.statement_end <= fin;
        @(posedge i_clk);
        while (!text_if.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
        stmts++;
    endtask

    task automatic wait_drained();
        text_if.valid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
    endtask

    function automatic logic [7:0] word_head();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'(8'h41 + r);
        if (r < 52) return 8'(8'h61 + r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] word_tail();
        int r;
        r = $urandom_range(0, 62);
        if (r < 10) return 8'(8'h30 + r);
        return word_head();
    endfunction

    function automatic logic [7:0] blank_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'(8'h09 + r);
    endfunction

    task automatic send_token();
        int         pick;
        int         len;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            send_byte(word_head());
            len = $urandom_range(0, 5);
            repeat (len) send_byte(word_tail());
        end else if (pick < 45) begin
            if ($urandom_range(0, 2) == 0) send_byte(CH_MINUS);
            len = $urandom_range(1, 4);
            repeat (len) send_byte(8'(8'h30 + $urandom_range(0, 9)));
        end else if (pick < 65) begin
            send_byte(CH_QUOTE);
            len = $urandom_range(0, 5);
            repeat (len) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_byte(CH_QUOTE);
                    send_byte(CH_QUOTE);
                end else begin
                    c = 8'($urandom_range(0, 255));
                    send_byte((c == CH_QUOTE) ? 8'h00 : c);
                end
            end
            send_byte(CH_QUOTE);
        end else if (pick < 85) begin
            send_byte(symbols[$urandom_range(0, 5)]);
        end else if (pick < 93) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            // minus with no digit after it
            send_byte(CH_MINUS);
            send_byte(($urandom_range(0, 1) != 0) ? word_head() : blank_byte());
        end
    endtask

    task automatic send_statement();
        int shape;
        int ntok;
        shape = $urandom_range(0, 99);
        if (shape < 4) begin
            send_end();
            return;
        end
        if (shape < 24) begin
            send_byte(CH_MARK0);
            send_byte(CH_MARK1);
            send_byte(CH_MARK2);
        end else if (shape < 28) begin
            send_byte(CH_MARK0);
            if ($urandom_range(0, 1) != 0) send_byte(CH_MARK1);
        end
        ntok = $urandom_range(1, 6);
        repeat (ntok) begin
            send_token();
            if ($urandom_range(0, 1) != 0) send_byte(blank_byte());
        end
        shape = $urandom_range(0, 99);
        if (shape < 5) begin
            send_byte(CH_MINUS);
        end else if (shape < 10) begin
            send_byte(CH_QUOTE);
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(32, 126)));
        end
        send_end();
    endtask

    initial begin
        logic [8:0] demo_q[$];
        int         random_start;
        bit         paused;
        text_if.valid         = 1'b0;
        text_if.text_byte     = 8'h00;
        text_if.statement_end = 1'b0;
        demo_q = {
            // mark, word, symbol, string with escaped quote, negative number
            9'h0EF, 9'h0BB, 9'h0BF, 9'h05F, 9'h07A, 9'h039, 9'h03D, 9'h027, 9'h027,
            9'h027, 9'h078, 9'h027, 9'h03B, 9'h02D, 9'h035, 9'h02A, END_MARK,
            END_MARK,                             // empty statement
            9'h0EF, 9'h041, 9'h0FF, END_MARK,     // broken mark, bytes after error
            9'h0EF, END_MARK,                     // mark cut by end
            9'h02D, END_MARK,                     // lone minus at end
            9'h080, END_MARK,                     // high byte outside string
            9'h027, END_MARK                      // open string at end
        };
        paused = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (demo_q[k]) begin
            send_item(demo_q[k][7:0], demo_q[k][8]);
            if (demo_q[k][8]) stmts++;
        end
        wait_drained();

        random_start = sent;
        while (sent < random_start + RANDOM_ITEMS) begin
            calm = (sent >= random_start + 200) && (sent < random_start + 350);
            if (!paused && sent >= random_start + 450) begin
                wait_drained();
                paused = 1'b1;
            end
            send_statement();
        end
        calm = 1'b0;

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d statements in %0d input transfers, %0d token results checked",
                 stmts, sent, checked_total);
        $display("including byte-order mark, escapes, lone minus, error and empty statements");
        if (fail_total == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", fail_total);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/stl_pkg.sv
design/stl_in_if.sv
design/stl_out_if.sv
design/sql_token_lexer_core.sv
bench/stl_lexer_checker.sv
bench/tb_sql_token_lexer_core.sv
